@@ hdl/btp_pkg.sv @@
`default_nettype none

package btp_pkg;

  // pc width of the request and response channels, and width of the mode register
  localparam int unsigned PC_W   = 32;
  localparam int unsigned MODE_W = 2;

  // saturating counter, range one to four, taken at three or more
  localparam int unsigned CNT_W = 3;
  localparam logic [CNT_W-1:0] CNT_MIN     = 3'd1;
  localparam logic [CNT_W-1:0] CNT_MAX     = 3'd4;
  localparam logic [CNT_W-1:0] CNT_TAKEN   = 3'd3;
  localparam logic [CNT_W-1:0] CNT_RESET   = 3'd3;
  localparam logic [CNT_W-1:0] CNT_INST_OK = 3'd2;
  localparam logic [CNT_W-1:0] CNT_INST_BAD = 3'd3;

  typedef enum logic {
    CMD_PREDICT = 1'b0,
    CMD_UPDATE  = 1'b1
  } cmd_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_STATIC  = 2'd0,
    MODE_COUNTER = 2'd1,
    MODE_LOCAL   = 2'd2
  } mode_e;

  // one step of a counter, clamped to its range
  function automatic logic [CNT_W-1:0] cnt_step(input logic [CNT_W-1:0] c, input logic up);
    logic [CNT_W-1:0] r;
    if (up) begin
      r = (c >= CNT_MAX) ? CNT_MAX : CNT_W'(c + 1'b1);
    end else begin
      r = (c <= CNT_MIN) ? CNT_MIN : CNT_W'(c - 1'b1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/btp_req_if.sv @@
`default_nettype none

interface btp_req_if import btp_pkg::*; ();
  logic            valid;
  logic            ready;
  cmd_e            cmd;
  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] actual_next;
  logic [PC_W-1:0] predicted_next;

  modport source (output valid, output cmd, output pc, output actual_next,
                  output predicted_next, input ready);
  modport sink   (input valid, input cmd, input pc, input actual_next,
                  input predicted_next, output ready);
endinterface

`default_nettype wire

@@ hdl/btp_rsp_if.sv @@
`default_nettype none

interface btp_rsp_if import btp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PC_W-1:0] next_pc;

  modport source (output valid, output next_pc, input ready);
  modport sink   (input valid, input next_pc, output ready);
endinterface

`default_nettype wire

@@ hdl/branch_target_predictor.sv @@
// Branch target predictor: a direct-mapped table of 2^IDX_W entries, indexed by the low
// pc bits, each holding a valid bit, the full pc as tag, a target, a local outcome history, a
// speculative history and four saturating counters. A predict request returns the stored target
// when the entry hits and the selected scheme says taken, else pc plus one (wrapping at
// ADDR_BITS); an update request trains the entry and returns nothing. The scheme comes from
// the mode register (static backward-taken, single counter, two-bit local history) and must
// only be written while no request is in flight. One request is taken per cycle, except while
// a predict waits in stage two behind a stalled response. A predict response is registered:
// its entry is read into stage two at the request transfer, and the response register is
// loaded from stage two once it can take the result, which a stalled response can delay. The
// rate is set by the single read-modify-write pass over the table: the entry is read at the request
// transfer and written back when stage two finishes, with a one-entry bypass for back-to-back
// requests to the same index. After reset the block runs a clearing pass over all 2^IDX_W
// table entries, during which no request is taken (mode writes are still accepted).
`default_nettype none

module branch_target_predictor import btp_pkg::*; #(
  parameter int unsigned IDX_W     = 6,
  parameter int unsigned ADDR_BITS = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [MODE_W-1:0] cfg_wdata_i,
  btp_req_if.sink                req_i,
  btp_rsp_if.source              rsp_o
);

  localparam int unsigned DEPTH = 1 << IDX_W;

  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [IDX_W-1:0]      idx_t;

  typedef struct packed {
    logic                  valid;
    addr_t                 tag;
    addr_t                 target;
    logic [1:0]            hist;
    logic [1:0]            spec;
    logic [3:0][CNT_W-1:0] cnt;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    valid:  1'b0,
    tag:    '0,
    target: '0,
    hist:   2'd0,
    spec:   2'd0,
    cnt:    {CNT_RESET, CNT_RESET, CNT_RESET, CNT_RESET}
  };

  // mode register
  mode_e mode_q;

  // clearing pass after reset
  logic clearing_q;
  idx_t clr_idx_q;

  // table memory and its registered read port
  entry_t mem [DEPTH];
  entry_t rd_q;
  logic   mem_we;
  idx_t   mem_waddr;
  entry_t mem_wdata;

  // second stage: request held while its entry is read
  logic  s2_valid_q;
  cmd_e  s2_cmd_q;
  addr_t s2_pc_q;
  addr_t s2_act_q;
  addr_t s2_prd_q;
  idx_t  s2_idx_q;

  // bypass of the entry written back in the same cycle as the read
  logic   fwd_sel_q;
  entry_t fwd_q;

  // response register
  logic            out_valid_q;
  logic [PC_W-1:0] out_pc_q;

  logic   req_fire;
  addr_t  req_pc;
  idx_t   req_idx;
  logic   s2_go;
  logic   s2_free;
  entry_t cur;
  entry_t upd;
  addr_t  next_a;

  // request side
  assign req_pc   = ADDR_BITS'(req_i.pc);
  assign req_idx  = IDX_W'(req_pc);
  // a predict in stage two finishes only when the response register can take it
  assign s2_go    = s2_valid_q &&
                    ((s2_cmd_q != CMD_PREDICT) || !out_valid_q || rsp_o.ready);
  assign s2_free  = !s2_valid_q || s2_go;
  assign req_i.ready = !clearing_q && s2_free;
  assign req_fire = req_i.valid && req_i.ready;

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.next_pc = out_pc_q;

  // entry as seen by stage two: bypassed when the previous request wrote the same index
  assign cur = fwd_sel_q ? fwd_q : rd_q;

  // prediction and training of one entry
  always_comb begin
    logic       hit;
    logic       correct;
    logic       taken;
    logic       up;
    logic [1:0] s;
    logic [1:0] h;
    addr_t      fall;
    upd     = cur;
    hit     = cur.valid && (cur.tag == s2_pc_q);
    correct = (s2_act_q == s2_prd_q);
    taken   = (s2_act_q == cur.target);
    fall    = s2_pc_q + 1'b1;
    next_a  = fall;
    up      = 1'b0;
    s       = {cur.spec[0], 1'b0};
    h       = {cur.hist[0], taken};
    if (s2_cmd_q == CMD_PREDICT) begin
      if (hit) begin
        case (mode_q)
          MODE_STATIC: begin
            // backward branches are taken
            if (cur.target < s2_pc_q) begin
              next_a = cur.target;
            end
          end
          MODE_COUNTER: begin
            if (cur.cnt[0] >= CNT_TAKEN) begin
              next_a = cur.target;
            end
          end
          MODE_LOCAL: begin
            // speculative history shifts in the predicted outcome
            if (cur.cnt[s] >= CNT_TAKEN) begin
              s      = s | 2'd1;
              next_a = cur.target;
            end
            upd.spec = s;
          end
          default: begin
          end
        endcase
      end
    end else begin
      case (mode_q)
        MODE_STATIC: begin
          upd.valid  = 1'b1;
          upd.tag    = s2_pc_q;
          upd.target = s2_act_q;
        end
        MODE_COUNTER: begin
          if (hit) begin
            // weak side trains toward a flip when wrong, strong side toward taken when right
            up = (cur.cnt[0] < CNT_TAKEN) ? !correct : correct;
            upd.cnt[0] = cnt_step(cur.cnt[0], up);
          end else begin
            upd.valid  = 1'b1;
            upd.tag    = s2_pc_q;
            upd.target = s2_act_q;
            upd.cnt[0] = correct ? CNT_INST_OK : CNT_INST_BAD;
          end
        end
        MODE_LOCAL: begin
          if (hit) begin
            upd.hist = h;
            if (!correct) begin
              upd.spec = h;
            end
            upd.cnt[h] = cnt_step(cur.cnt[h], taken);
          end else begin
            upd.valid  = 1'b1;
            upd.tag    = s2_pc_q;
            upd.target = s2_act_q;
            for (int k = 0; k < 4; k++) begin
              upd.cnt[k] = correct ? CNT_INST_OK : CNT_INST_BAD;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // single write port: clearing pass, then write-back of each finished request
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = s2_idx_q;
    mem_wdata = upd;
    if (clearing_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_q;
      mem_wdata = ENTRY_RESET;
    end else if (s2_go) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (req_fire) begin
      rd_q <= mem[req_idx];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_COUNTER;
      clearing_q  <= 1'b1;
      clr_idx_q   <= '0;
      s2_valid_q  <= 1'b0;
      fwd_sel_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= mode_e'(cfg_wdata_i);
      end
      if (clearing_q) begin
        clr_idx_q <= IDX_W'(clr_idx_q + 1'b1);
        if (clr_idx_q == '1) begin
          clearing_q <= 1'b0;
        end
      end
      if (req_fire) begin
        s2_valid_q <= 1'b1;
        fwd_sel_q  <= s2_go && (s2_idx_q == req_idx);
      end else if (s2_go) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_go && (s2_cmd_q == CMD_PREDICT)) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      s2_cmd_q <= req_i.cmd;
      s2_pc_q  <= req_pc;
      s2_act_q <= ADDR_BITS'(req_i.actual_next);
      s2_prd_q <= ADDR_BITS'(req_i.predicted_next);
      s2_idx_q <= req_idx;
      fwd_q    <= upd;
    end
    if (s2_go && (s2_cmd_q == CMD_PREDICT)) begin
      out_pc_q <= PC_W'(next_a);
    end
  end

endmodule

`default_nettype wire

@@ hdl/btp_checker.sv @@
`default_nettype none

module btp_checker import btp_pkg::*; (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            req_valid_i,
  input wire logic            req_ready_i,
  input wire cmd_e            req_cmd_i,
  input wire logic            rsp_valid_i,
  input wire logic            rsp_ready_i,
  input wire logic [PC_W-1:0] rsp_next_pc_i
);

  // a stalled response stays offered
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  // a stalled response keeps its payload
  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_next_pc_i))
    else $error("response payload changed while stalled");

  // a predict transfer has a response offered by the time it has passed stage two and the response register
  a_predict_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && (req_cmd_i == CMD_PREDICT) |=> ##1 rsp_valid_i)
    else $error("predict not answered two cycles after its transfer");

  // table clearing holds off requests right after reset
  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !req_ready_i)
    else $error("request taken before table clearing");

endmodule

bind branch_target_predictor btp_checker u_btp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .req_cmd_i     (req_i.cmd),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_next_pc_i (rsp_o.next_pc)
);

`default_nettype wire
